>>> rtl/rcc_pkg.sv
package rcc_pkg;

   localparam int FRAC_BITS = 16;

   // Pipeline depths of the separate units.
   localparam int FRONT_LAT = 9;
   localparam int SQRT_LAT  = 33;
   localparam int DIV_LAT   = 33;
   localparam int BACK_LAT  = 4;

   // Divider numerator: -k +/- sqrt needs up to 35 signed bits.
   localparam int DIV_NUM_W = 35;

   localparam logic [31:0]        RADIUS_SQ_RESET = 32'(64'd1 << FRAC_BITS);
   localparam logic [30:0]        LENGTH_RESET    = 31'(64'd1 << FRAC_BITS);
   localparam logic signed [31:0] DIST_MISS       = 32'sh7FFF_FFFF;

   typedef enum logic {
      CSR_RADIUS_SQ = 1'b0,
      CSR_LENGTH    = 1'b1
   } csr_index_type;

   typedef logic [2:0][31:0] vec3_type;

   // Per-ray values carried alongside the square root and dividers.
   typedef struct packed {
      logic               a_zero;
      logic               lat_ok;
      logic signed [31:0] a;
      logic signed [31:0] k;
      logic signed [31:0] delta;
      logic signed [31:0] beta;
      logic signed [31:0] dxf;
      vec3_type           x;
      vec3_type           xf;
      vec3_type           dir;
   } side_type;

   function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
      logic signed [31:0] r;
      if (v > 66'sd2147483647) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -66'sd2147483648) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic signed [63:0] mul(input logic [31:0] a, input logic [31:0] b);
      return $signed(a) * $signed(b);
   endfunction

   // Floor shift of a full product, then saturate.
   function automatic logic signed [31:0] fmul_out(input logic signed [63:0] p);
      logic signed [63:0] s;
      s = p >>> FRAC_BITS;
      return sat32(66'(s));
   endfunction

   function automatic logic signed [31:0] add_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      return sat32(66'(a) + 66'(b));
   endfunction

   function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
      return sat32(66'(a) - 66'(b));
   endfunction

   function automatic logic signed [31:0] sum3(input logic signed [63:0] p0,
                                              input logic signed [63:0] p1,
                                              input logic signed [63:0] p2);
      return sat32(66'(fmul_out(p0)) + 66'(fmul_out(p1)) + 66'(fmul_out(p2)));
   endfunction

endpackage

>>> rtl/rcc_front.sv
module rcc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 in_vld,
   input  rcc_pkg::vec3_type    org,
   input  rcc_pkg::vec3_type    dir,
   input  rcc_pkg::vec3_type    base,
   input  rcc_pkg::vec3_type    axis,
   input  logic [31:0]          radius_sq,
   input  logic [30:0]          cyl_len,
   output logic                 out_vld,
   output rcc_pkg::side_type    out_side,
   output logic signed [63:0]   out_d1
);
   import rcc_pkg::*;

   logic [FRONT_LAT-1:0] vld_ff;

   vec3_type x_s1_ff, dir_s1_ff, ax_s1_ff, org_s1_ff, base_s1_ff;
   logic signed [63:0] pl_s1_ff [3];

   vec3_type x_s2_ff, dir_s2_ff, ax_s2_ff, org_s2_ff, bl_s2_ff;
   logic signed [63:0] pda_s2_ff [3];
   logic signed [63:0] pxa_s2_ff [3];

   vec3_type x_s3_ff, dir_s3_ff, ax_s3_ff, xf_s3_ff;
   logic signed [31:0] delta_s3_ff, beta_s3_ff;

   vec3_type x_s4_ff, dir_s4_ff, xf_s4_ff;
   logic signed [31:0] delta_s4_ff, beta_s4_ff;
   logic signed [63:0] pdl_s4_ff [3];
   logic signed [63:0] pbt_s4_ff [3];
   logic signed [63:0] pxf_s4_ff [3];

   vec3_type x_s5_ff, dir_s5_ff, xf_s5_ff, iv_s5_ff, jv_s5_ff;
   logic signed [31:0] delta_s5_ff, beta_s5_ff, dxf_s5_ff;

   vec3_type x_s6_ff, dir_s6_ff, xf_s6_ff;
   logic signed [31:0] delta_s6_ff, beta_s6_ff, dxf_s6_ff;
   logic signed [63:0] pii_s6_ff [3];
   logic signed [63:0] pij_s6_ff [3];
   logic signed [63:0] pjj_s6_ff [3];

   vec3_type x_s7_ff, dir_s7_ff, xf_s7_ff;
   logic signed [31:0] delta_s7_ff, beta_s7_ff, dxf_s7_ff, a_s7_ff, k_s7_ff, c_s7_ff;

   vec3_type x_s8_ff, dir_s8_ff, xf_s8_ff;
   logic signed [31:0] delta_s8_ff, beta_s8_ff, dxf_s8_ff, a_s8_ff, k_s8_ff;
   logic signed [63:0] kk_s8_ff, ac_s8_ff;

   logic signed [63:0] d1_in;
   side_type           side_ff;
   logic signed [63:0] d1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[FRONT_LAT-2:0], in_vld};
      end
   end

   assign d1_in = kk_s8_ff - ac_s8_ff;

   always_ff @(posedge clock) begin
      // offset from base cap, far cap offset along the axis
      for (int n = 0; n < 3; n++) begin
         x_s1_ff[n]  <= sub_sat(org[n], base[n]);
         pl_s1_ff[n] <= mul({1'b0, cyl_len}, axis[n]);
      end
      dir_s1_ff  <= dir;
      ax_s1_ff   <= axis;
      org_s1_ff  <= org;
      base_s1_ff <= base;

      for (int n = 0; n < 3; n++) begin
         pda_s2_ff[n] <= mul(dir_s1_ff[n], ax_s1_ff[n]);
         pxa_s2_ff[n] <= mul(x_s1_ff[n], ax_s1_ff[n]);
         bl_s2_ff[n]  <= add_sat(base_s1_ff[n], fmul_out(pl_s1_ff[n]));
      end
      x_s2_ff   <= x_s1_ff;
      dir_s2_ff <= dir_s1_ff;
      ax_s2_ff  <= ax_s1_ff;
      org_s2_ff <= org_s1_ff;

      delta_s3_ff <= sum3(pda_s2_ff[0], pda_s2_ff[1], pda_s2_ff[2]);
      beta_s3_ff  <= sum3(pxa_s2_ff[0], pxa_s2_ff[1], pxa_s2_ff[2]);
      for (int n = 0; n < 3; n++) begin
         xf_s3_ff[n] <= sub_sat(org_s2_ff[n], bl_s2_ff[n]);
      end
      x_s3_ff   <= x_s2_ff;
      dir_s3_ff <= dir_s2_ff;
      ax_s3_ff  <= ax_s2_ff;

      for (int n = 0; n < 3; n++) begin
         pdl_s4_ff[n] <= mul(delta_s3_ff, ax_s3_ff[n]);
         pbt_s4_ff[n] <= mul(beta_s3_ff, ax_s3_ff[n]);
         pxf_s4_ff[n] <= mul(xf_s3_ff[n], ax_s3_ff[n]);
      end
      x_s4_ff     <= x_s3_ff;
      dir_s4_ff   <= dir_s3_ff;
      xf_s4_ff    <= xf_s3_ff;
      delta_s4_ff <= delta_s3_ff;
      beta_s4_ff  <= beta_s3_ff;

      // split direction and offset into parts normal to the axis
      for (int n = 0; n < 3; n++) begin
         iv_s5_ff[n] <= sub_sat(dir_s4_ff[n], fmul_out(pdl_s4_ff[n]));
         jv_s5_ff[n] <= sub_sat(x_s4_ff[n], fmul_out(pbt_s4_ff[n]));
      end
      dxf_s5_ff   <= sum3(pxf_s4_ff[0], pxf_s4_ff[1], pxf_s4_ff[2]);
      x_s5_ff     <= x_s4_ff;
      dir_s5_ff   <= dir_s4_ff;
      xf_s5_ff    <= xf_s4_ff;
      delta_s5_ff <= delta_s4_ff;
      beta_s5_ff  <= beta_s4_ff;

      for (int n = 0; n < 3; n++) begin
         pii_s6_ff[n] <= mul(iv_s5_ff[n], iv_s5_ff[n]);
         pij_s6_ff[n] <= mul(iv_s5_ff[n], jv_s5_ff[n]);
         pjj_s6_ff[n] <= mul(jv_s5_ff[n], jv_s5_ff[n]);
      end
      x_s6_ff     <= x_s5_ff;
      dir_s6_ff   <= dir_s5_ff;
      xf_s6_ff    <= xf_s5_ff;
      delta_s6_ff <= delta_s5_ff;
      beta_s6_ff  <= beta_s5_ff;
      dxf_s6_ff   <= dxf_s5_ff;

      a_s7_ff <= sum3(pii_s6_ff[0], pii_s6_ff[1], pii_s6_ff[2]);
      k_s7_ff <= sum3(pij_s6_ff[0], pij_s6_ff[1], pij_s6_ff[2]);
      c_s7_ff <= sat32(66'(sum3(pjj_s6_ff[0], pjj_s6_ff[1], pjj_s6_ff[2]))
                       - 66'({1'b0, radius_sq}));
      x_s7_ff     <= x_s6_ff;
      dir_s7_ff   <= dir_s6_ff;
      xf_s7_ff    <= xf_s6_ff;
      delta_s7_ff <= delta_s6_ff;
      beta_s7_ff  <= beta_s6_ff;
      dxf_s7_ff   <= dxf_s6_ff;

      kk_s8_ff    <= mul(k_s7_ff, k_s7_ff);
      ac_s8_ff    <= mul(a_s7_ff, c_s7_ff);
      a_s8_ff     <= a_s7_ff;
      k_s8_ff     <= k_s7_ff;
      x_s8_ff     <= x_s7_ff;
      dir_s8_ff   <= dir_s7_ff;
      xf_s8_ff    <= xf_s7_ff;
      delta_s8_ff <= delta_s7_ff;
      beta_s8_ff  <= beta_s7_ff;
      dxf_s8_ff   <= dxf_s7_ff;

      // discriminant, exact in double fraction width
      d1_ff          <= d1_in;
      side_ff.a_zero <= (a_s8_ff == 32'sd0);
      side_ff.lat_ok <= !d1_in[63];
      side_ff.a      <= a_s8_ff;
      side_ff.k      <= k_s8_ff;
      side_ff.delta  <= delta_s8_ff;
      side_ff.beta   <= beta_s8_ff;
      side_ff.dxf    <= dxf_s8_ff;
      side_ff.x      <= x_s8_ff;
      side_ff.xf     <= xf_s8_ff;
      side_ff.dir    <= dir_s8_ff;
   end

   assign out_vld  = vld_ff[FRONT_LAT-1];
   assign out_side = side_ff;
   assign out_d1   = d1_ff;

endmodule

>>> rtl/rcc_sqrt.sv
module rcc_sqrt (
   input  logic        clock,
   input  logic [62:0] value,
   output logic [31:0] root
);
   import rcc_pkg::*;

   localparam int STEPS = SQRT_LAT - 1;

   logic [63:0] val_ff [STEPS];
   logic [33:0] rem_ff [STEPS+1];
   logic [31:0] rt_ff  [STEPS+1];
   logic [33:0] rem_in [STEPS+1];
   logic [31:0] rt_in  [STEPS+1];

   // One result bit per stage, two radicand bits consumed per stage.
   always_comb begin
      logic [35:0] sh;
      logic [35:0] tr;
      logic        ge;
      int          i;
      rem_in[0] = '0;
      rt_in[0]  = '0;
      for (int s = 1; s <= STEPS; s++) begin
         i  = STEPS - s;
         sh = {rem_ff[s-1], val_ff[s-1][2*i +: 2]};
         tr = {2'b00, rt_ff[s-1], 2'b01};
         ge = (sh >= tr);
         rem_in[s] = ge ? 34'(sh - tr) : sh[33:0];
         rt_in[s]  = {rt_ff[s-1][30:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      val_ff[0] <= {1'b0, value};
      rem_ff[0] <= rem_in[0];
      rt_ff[0]  <= rt_in[0];
      for (int s = 1; s <= STEPS; s++) begin
         rem_ff[s] <= rem_in[s];
         rt_ff[s]  <= rt_in[s];
      end
      for (int s = 1; s < STEPS; s++) begin
         val_ff[s] <= val_ff[s-1];
      end
   end

   assign root = rt_ff[STEPS];

endmodule

>>> rtl/rcc_div.sv
module rcc_div (
   input  logic                                  clock,
   input  logic signed [rcc_pkg::DIV_NUM_W-1:0]  num,
   input  logic signed [31:0]                    den,
   output logic signed [31:0]                    quo
);
   import rcc_pkg::*;

   localparam int NW = DIV_NUM_W + FRAC_BITS;
   localparam int QB = 31;

   logic [DIV_NUM_W-1:0] num_mag;
   logic [31:0]          den_mag;
   logic [NW-1:0]        dvd;
   logic [31:0]          hi;
   logic                 ovf;

   logic [31:0]   rem_ff [QB+1];
   logic [QB-1:0] quo_ff [QB+1];
   logic [QB-1:0] low_ff [QB];
   logic [31:0]   den_ff [QB];
   logic          neg_ff [QB+1];
   logic          ovf_ff [QB+1];
   logic [31:0]   rem_in [QB+1];
   logic [QB-1:0] quo_in [QB+1];
   logic signed [31:0] res_ff;

   assign num_mag = num[DIV_NUM_W-1] ? DIV_NUM_W'(-num) : DIV_NUM_W'(num);
   assign den_mag = den[31] ? 32'(-den) : 32'(den);
   assign dvd     = {num_mag, {FRAC_BITS{1'b0}}};
   assign hi      = 32'(dvd[NW-1:QB]);
   // quotient would not fit in 31 bits: saturate
   assign ovf     = (hi >= den_mag);

   always_comb begin
      logic [32:0] trial;
      logic        ge;
      int          b;
      rem_in[0] = ovf ? '0 : hi;
      quo_in[0] = '0;
      for (int s = 1; s <= QB; s++) begin
         b     = QB - s;
         trial = {rem_ff[s-1], low_ff[s-1][b]};
         ge    = (trial >= {1'b0, den_ff[s-1]});
         rem_in[s] = ge ? 32'(trial - {1'b0, den_ff[s-1]}) : trial[31:0];
         quo_in[s] = quo_ff[s-1] | (QB'(ge) << b);
      end
   end

   always_ff @(posedge clock) begin
      rem_ff[0] <= rem_in[0];
      quo_ff[0] <= quo_in[0];
      low_ff[0] <= dvd[QB-1:0];
      den_ff[0] <= den_mag;
      neg_ff[0] <= num[DIV_NUM_W-1] ^ den[31];
      ovf_ff[0] <= ovf;
      for (int s = 1; s <= QB; s++) begin
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
         neg_ff[s] <= neg_ff[s-1];
         ovf_ff[s] <= ovf_ff[s-1];
      end
      for (int s = 1; s < QB; s++) begin
         low_ff[s] <= low_ff[s-1];
         den_ff[s] <= den_ff[s-1];
      end
      if (ovf_ff[QB]) begin
         res_ff <= neg_ff[QB] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else if (neg_ff[QB]) begin
         res_ff <= -$signed({1'b0, quo_ff[QB]});
      end else begin
         res_ff <= $signed({1'b0, quo_ff[QB]});
      end
   end

   assign quo = res_ff;

endmodule

>>> rtl/rcc_back.sv
module rcc_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_vld,
   input  rcc_pkg::side_type   side,
   input  logic signed [31:0]  r1,
   input  logic signed [31:0]  r2,
   input  logic signed [31:0]  tc1,
   input  logic signed [31:0]  tc2,
   input  logic [31:0]         radius_sq,
   input  logic [30:0]         cyl_len,
   output logic                out_vld,
   output logic                out_hit,
   output logic signed [31:0]  out_dist
);
   import rcc_pkg::*;

   logic [BACK_LAT-1:0] vld_ff;

   side_type side_b1_ff, side_b2_ff, side_b3_ff;
   logic signed [31:0] r1_b1_ff, r2_b1_ff, tc1_b1_ff, tc2_b1_ff;
   logic signed [31:0] r1_b2_ff, r2_b2_ff, tc1_b2_ff, tc2_b2_ff;
   logic signed [31:0] r1_b3_ff, r2_b3_ff, tc1_b3_ff, tc2_b3_ff;
   logic signed [63:0] pm1_b1_ff, pm2_b1_ff;
   logic signed [63:0] pf1_b1_ff [3];
   logic signed [63:0] pf2_b1_ff [3];
   logic signed [31:0] m1_b2_ff, m2_b2_ff;
   vec3_type           f1_b2_ff, f2_b2_ff;
   logic signed [63:0] pq1_b3_ff [3];
   logic signed [63:0] pq2_b3_ff [3];
   logic               in1_b3_ff, in2_b3_ff;

   logic               hit_ff;
   logic signed [31:0] dist_ff;

   logic signed [31:0] q1, q2;
   logic               cap1, cap2;
   logic               hit_in;
   logic signed [31:0] dist_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[BACK_LAT-2:0], in_vld};
      end
   end

   always_ff @(posedge clock) begin
      pm1_b1_ff <= mul(r1, side.delta);
      pm2_b1_ff <= mul(r2, side.delta);
      for (int n = 0; n < 3; n++) begin
         pf1_b1_ff[n] <= mul(tc1, side.dir[n]);
         pf2_b1_ff[n] <= mul(tc2, side.dir[n]);
      end
      side_b1_ff <= side;
      r1_b1_ff   <= r1;
      r2_b1_ff   <= r2;
      tc1_b1_ff  <= tc1;
      tc2_b1_ff  <= tc2;

      // axial position of lateral roots, cap plane hit points
      m1_b2_ff <= add_sat(side_b1_ff.beta, fmul_out(pm1_b1_ff));
      m2_b2_ff <= add_sat(side_b1_ff.beta, fmul_out(pm2_b1_ff));
      for (int n = 0; n < 3; n++) begin
         f1_b2_ff[n] <= add_sat(side_b1_ff.x[n], fmul_out(pf1_b1_ff[n]));
         f2_b2_ff[n] <= add_sat(side_b1_ff.xf[n], fmul_out(pf2_b1_ff[n]));
      end
      side_b2_ff <= side_b1_ff;
      r1_b2_ff   <= r1_b1_ff;
      r2_b2_ff   <= r2_b1_ff;
      tc1_b2_ff  <= tc1_b1_ff;
      tc2_b2_ff  <= tc2_b1_ff;

      for (int n = 0; n < 3; n++) begin
         pq1_b3_ff[n] <= mul(f1_b2_ff[n], f1_b2_ff[n]);
         pq2_b3_ff[n] <= mul(f2_b2_ff[n], f2_b2_ff[n]);
      end
      in1_b3_ff  <= side_b2_ff.lat_ok && !m1_b2_ff[31]
                    && (m1_b2_ff <= $signed({1'b0, cyl_len}));
      in2_b3_ff  <= side_b2_ff.lat_ok && !m2_b2_ff[31]
                    && (m2_b2_ff <= $signed({1'b0, cyl_len}));
      side_b3_ff <= side_b2_ff;
      r1_b3_ff   <= r1_b2_ff;
      r2_b3_ff   <= r2_b2_ff;
      tc1_b3_ff  <= tc1_b2_ff;
      tc2_b3_ff  <= tc2_b2_ff;

      hit_ff  <= hit_in;
      dist_ff <= dist_in;
   end

   assign q1   = sum3(pq1_b3_ff[0], pq1_b3_ff[1], pq1_b3_ff[2]);
   assign q2   = sum3(pq2_b3_ff[0], pq2_b3_ff[1], pq2_b3_ff[2]);
   assign cap1 = (side_b3_ff.delta != 32'sd0)
                 && ($signed({q1[31], q1}) < $signed({1'b0, radius_sq}));
   assign cap2 = (side_b3_ff.delta != 32'sd0)
                 && ($signed({q2[31], q2}) < $signed({1'b0, radius_sq}));

   // Pick the nearest candidate; a later one wins only when strictly nearer. A zero lateral term forces a miss.
   always_comb begin
      logic               v;
      logic signed [31:0] t;
      v = in1_b3_ff;
      t = r1_b3_ff;
      if (in2_b3_ff && (!v || r2_b3_ff < t)) begin
         v = 1'b1;
         t = r2_b3_ff;
      end
      if (cap1 && (!v || tc1_b3_ff < t)) begin
         v = 1'b1;
         t = tc1_b3_ff;
      end
      if (cap2 && (!v || tc2_b3_ff < t)) begin
         v = 1'b1;
         t = tc2_b3_ff;
      end
      if (side_b3_ff.a_zero) begin
         v = 1'b0;
      end
      hit_in  = v;
      dist_in = v ? t : DIST_MISS;
   end

   assign out_vld  = vld_ff[BACK_LAT-1];
   assign out_hit  = hit_ff;
   assign out_dist = dist_ff;

endmodule

>>> rtl/ray_capped_cylinder_intersect_top.sv
// Ray versus capped cylinder intersection, fully pipelined.
// From the start edge to the rsp_valid strobe an item passes the front end, square root,
// dividers and select stages. Throughput: one item per cycle; the receiver cannot stall.
// The square root and the four dividers each resolve one result bit per stage.
// Synchronous active-high reset clears all valid bits and sets radius squared and length
// to 1.0; busy and csr_ready are only held off while reset is asserted.
module ray_capped_cylinder_intersect_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_origin_x,
   input  logic signed [31:0] req_origin_y,
   input  logic signed [31:0] req_origin_z,
   input  logic signed [31:0] req_dir_x,
   input  logic signed [31:0] req_dir_y,
   input  logic signed [31:0] req_dir_z,
   input  logic signed [31:0] req_base_x,
   input  logic signed [31:0] req_base_y,
   input  logic signed [31:0] req_base_z,
   input  logic signed [31:0] req_axis_x,
   input  logic signed [31:0] req_axis_y,
   input  logic signed [31:0] req_axis_z,
   output logic               rsp_valid,
   output logic               rsp_hit,
   output logic signed [31:0] rsp_distance,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic               csr_index,
   input  logic [31:0]        csr_wdata
);
   import rcc_pkg::*;

   localparam int TOTAL_LAT = FRONT_LAT + SQRT_LAT + DIV_LAT + BACK_LAT;

   // Configuration registers
   logic [31:0] radius_sq_ff, radius_sq_in;
   logic [30:0] cyl_len_ff, cyl_len_in;

   logic     req_take;
   vec3_type org, dir, base, axis;

   logic               fr_vld;
   side_type           fr_side;
   logic signed [63:0] fr_d1;

   // Side values ride next to the square root, then next to the dividers.
   side_type             sq_side_ff [SQRT_LAT];
   logic [SQRT_LAT-1:0]  sq_vld_ff;
   side_type             dv_side_ff [DIV_LAT];
   logic [DIV_LAT-1:0]   dv_vld_ff;

   logic [31:0]                  iota;
   side_type                     sq_out;
   logic signed [DIV_NUM_W-1:0]  num_r1, num_r2, num_c1, num_c2;
   logic signed [31:0]           r1, r2, tc1, tc2;

   assign busy      = reset;
   assign csr_ready = !reset;
   assign req_take  = start && !busy;

   always_comb begin
      radius_sq_in = radius_sq_ff;
      cyl_len_in   = cyl_len_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_RADIUS_SQ: radius_sq_in = csr_wdata;
            CSR_LENGTH:    cyl_len_in   = csr_wdata[30:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_ff <= RADIUS_SQ_RESET;
         cyl_len_ff   <= LENGTH_RESET;
      end else begin
         radius_sq_ff <= radius_sq_in;
         cyl_len_ff   <= cyl_len_in;
      end
   end

   assign org  = {req_origin_z, req_origin_y, req_origin_x};
   assign dir  = {req_dir_z, req_dir_y, req_dir_x};
   assign base = {req_base_z, req_base_y, req_base_x};
   assign axis = {req_axis_z, req_axis_y, req_axis_x};

   // Projections, normal parts, quadratic terms and discriminant
   rcc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (req_take),
      .org       (org),
      .dir       (dir),
      .base      (base),
      .axis      (axis),
      .radius_sq (radius_sq_ff),
      .cyl_len   (cyl_len_ff),
      .out_vld   (fr_vld),
      .out_side  (fr_side),
      .out_d1    (fr_d1)
   );

   // Negative discriminant: feed zero, the lateral roots get dropped later.
   rcc_sqrt u_sqrt (
      .clock (clock),
      .value (fr_d1[63] ? 63'd0 : fr_d1[62:0]),
      .root  (iota)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= '0;
         dv_vld_ff <= '0;
      end else begin
         sq_vld_ff <= {sq_vld_ff[SQRT_LAT-2:0], fr_vld};
         dv_vld_ff <= {dv_vld_ff[DIV_LAT-2:0], sq_vld_ff[SQRT_LAT-1]};
      end
   end

   always_ff @(posedge clock) begin
      sq_side_ff[0] <= fr_side;
      for (int i = 1; i < SQRT_LAT; i++) begin
         sq_side_ff[i] <= sq_side_ff[i-1];
      end
      dv_side_ff[0] <= sq_out;
      for (int i = 1; i < DIV_LAT; i++) begin
         dv_side_ff[i] <= dv_side_ff[i-1];
      end
   end

   assign sq_out = sq_side_ff[SQRT_LAT-1];

   // Lateral roots (-k +/- sqrt)/a, cap parameters -beta/delta and -(xf.axis)/delta
   assign num_r1 = -DIV_NUM_W'(sq_out.k) + DIV_NUM_W'(iota);
   assign num_r2 = -DIV_NUM_W'(sq_out.k) - DIV_NUM_W'(iota);
   assign num_c1 = -DIV_NUM_W'(sq_out.beta);
   assign num_c2 = -DIV_NUM_W'(sq_out.dxf);

   rcc_div u_div_r1 (.clock(clock), .num(num_r1), .den(sq_out.a),     .quo(r1));
   rcc_div u_div_r2 (.clock(clock), .num(num_r2), .den(sq_out.a),     .quo(r2));
   rcc_div u_div_c1 (.clock(clock), .num(num_c1), .den(sq_out.delta), .quo(tc1));
   rcc_div u_div_c2 (.clock(clock), .num(num_c2), .den(sq_out.delta), .quo(tc2));

   // Range checks and nearest-hit selection
   rcc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_vld    (dv_vld_ff[DIV_LAT-1]),
      .side      (dv_side_ff[DIV_LAT-1]),
      .r1        (r1),
      .r2        (r2),
      .tc1       (tc1),
      .tc2       (tc2),
      .radius_sq (radius_sq_ff),
      .cyl_len   (cyl_len_ff),
      .out_vld   (rsp_valid),
      .out_hit   (rsp_hit),
      .out_dist  (rsp_distance)
   );

`ifndef SYNTHESIS
   a_rsp_follows_req : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(req_take, TOTAL_LAT))
      else $error("result strobe without an item accepted at the pipeline depth");

   a_mid_follows_front : assert property (@(posedge clock) disable iff (reset)
      dv_vld_ff[DIV_LAT-1] |-> $past(fr_vld, SQRT_LAT + DIV_LAT))
      else $error("divider output valid out of step with front end");

   a_miss_distance : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_distance == DIST_MISS)
      else $error("miss reported with a distance other than the maximum");
`endif

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import rcc_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 100;   // comfortably above the pipeline depth
   localparam int ONE = 65536;

   typedef longint triple_type [3];

   typedef struct {
      logic signed [31:0] o [3];
      logic signed [31:0] d [3];
      logic signed [31:0] b [3];
      logic signed [31:0] ax [3];
   } ray_type;

   typedef struct {
      logic               hit;
      logic signed [31:0] distance;
   } hit_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_origin_x, req_origin_y, req_origin_z;
   logic signed [31:0] req_dir_x, req_dir_y, req_dir_z;
   logic signed [31:0] req_base_x, req_base_y, req_base_z;
   logic signed [31:0] req_axis_x, req_axis_y, req_axis_z;
   logic               rsp_valid;
   logic               rsp_hit;
   logic signed [31:0] rsp_distance;
   logic               csr_valid;
   logic               csr_ready;
   logic               csr_index;
   logic [31:0]        csr_wdata;

   // Local copy of the two registers, updated as each write is taken.
   longint radius_sq_q;
   longint length_q;

   hit_type expected_hits [$];
   int      errors;
   int      cycles;

   ray_capped_cylinder_intersect_top u_top (.*);

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Fixed point predictor
   // ---------------------------------------------------------------
   function automatic longint clamp32(input logic signed [67:0] v);
      if (v > 68'sd2147483647) return 64'sd2147483647;
      if (v < -68'sd2147483648) return -64'sd2147483648;
      return longint'(v);
   endfunction

   // product floored by the fraction width, then clamped
   function automatic longint qmul(input longint a, input longint b);
      longint p;
      p = a * b;
      return clamp32(68'(p >>> FRAC_BITS));
   endfunction

   function automatic longint qdot(input triple_type a, input triple_type b);
      return clamp32(68'(qmul(a[0], b[0])) + 68'(qmul(a[1], b[1])) + 68'(qmul(a[2], b[2])));
   endfunction

   // truncating divide of num * 2^FRAC_BITS; den is never zero here
   function automatic longint qdiv(input longint num, input longint den);
      return clamp32(68'((num * (64'sd1 <<< FRAC_BITS)) / den));
   endfunction

   function automatic longint floor_sqrt(input logic [67:0] v);
      logic [67:0] r, bitv;
      r = '0;
      bitv = 68'd1 << 66;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= r + bitv) begin
            v = v - (r + bitv);
            r = (r >> 1) + bitv;
         end else begin
            r = r >> 1;
         end
         bitv = bitv >> 2;
      end
      return longint'(r);
   endfunction

   function automatic hit_type nearest_hit(input ray_type ray);
      triple_type o, d, b, ax, x, iv, jv, f, x2;
      longint delta, beta, a, k, c, iota, r, m, t, tc;
      logic signed [67:0] disc;
      logic found;
      hit_type res;
      found = 1'b0;
      t = 0;
      for (int n = 0; n < 3; n++) begin
         o[n] = ray.o[n];
         d[n] = ray.d[n];
         b[n] = ray.b[n];
         ax[n] = ray.ax[n];
         x[n] = clamp32(68'(o[n]) - 68'(b[n]));
      end
      delta = qdot(d, ax);
      beta = qdot(x, ax);
      for (int n = 0; n < 3; n++) begin
         iv[n] = clamp32(68'(d[n]) - 68'(qmul(delta, ax[n])));
         jv[n] = clamp32(68'(x[n]) - 68'(qmul(beta, ax[n])));
      end
      a = qdot(iv, iv);
      res.hit = 1'b0;
      res.distance = DIST_MISS;
      // direction parallel to the axis: always a miss
      if (a == 0) return res;

      k = qdot(iv, jv);
      c = clamp32(68'(qdot(jv, jv)) - 68'(radius_sq_q));
      disc = 68'(k) * 68'(k) - 68'(a) * 68'(c);
      if (disc >= 0) begin
         iota = floor_sqrt(disc);
         r = qdiv(-k + iota, a);
         m = clamp32(68'(beta) + 68'(qmul(r, delta)));
         if (m >= 0 && m <= length_q) begin
            found = 1'b1;
            t = r;
         end
         r = qdiv(-k - iota, a);
         m = clamp32(68'(beta) + 68'(qmul(r, delta)));
         if ((!found || r < t) && m >= 0 && m <= length_q) begin
            found = 1'b1;
            t = r;
         end
      end

      // caps only when the ray has an axial component
      if (delta != 0) begin
         tc = qdiv(-beta, delta);
         for (int n = 0; n < 3; n++) f[n] = clamp32(68'(x[n]) + 68'(qmul(tc, d[n])));
         if ((!found || tc < t) && qdot(f, f) < radius_sq_q) begin
            found = 1'b1;
            t = tc;
         end
         for (int n = 0; n < 3; n++)
            x2[n] = clamp32(68'(o[n]) - 68'(clamp32(68'(b[n]) + 68'(qmul(length_q, ax[n])))));
         tc = qdiv(-qdot(x2, ax), delta);
         for (int n = 0; n < 3; n++) f[n] = clamp32(68'(x2[n]) + 68'(qmul(tc, d[n])));
         if ((!found || tc < t) && qdot(f, f) < radius_sq_q) begin
            found = 1'b1;
            t = tc;
         end
      end
      if (found) begin
         res.hit = 1'b1;
         res.distance = t[31:0];
      end
      return res;
   endfunction

   // ---------------------------------------------------------------
   // Result checker: the receiver cannot stall, so take every strobe
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      hit_type want;
      if (!reset && rsp_valid) begin
         if (expected_hits.size() == 0) begin
            $display("%0t: result with nothing pending: hit=%0b distance=%08h",
                     $time, rsp_hit, rsp_distance);
            errors++;
         end else begin
            want = expected_hits.pop_front();
            if (rsp_hit !== want.hit) begin
               $display("%0t: hit mismatch: expected %0b actual %0b",
                        $time, want.hit, rsp_hit);
               errors++;
            end
            if (rsp_distance !== want.distance) begin
               $display("%0t: distance mismatch: expected %08h actual %08h",
                        $time, want.distance, rsp_distance);
               errors++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------
   function automatic int pick_gap();
      int sel;
      sel = $urandom_range(0, 99);
      if (sel < 55) return 0;
      if (sel < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   // Drive one ray, hold until taken, record its expected result.
   task automatic send_ray(input ray_type ray, input bit with_gaps);
      int gap;
      req_origin_x <= ray.o[0];  req_origin_y <= ray.o[1];  req_origin_z <= ray.o[2];
      req_dir_x    <= ray.d[0];  req_dir_y    <= ray.d[1];  req_dir_z    <= ray.d[2];
      req_base_x   <= ray.b[0];  req_base_y   <= ray.b[1];  req_base_z   <= ray.b[2];
      req_axis_x   <= ray.ax[0]; req_axis_y   <= ray.ax[1]; req_axis_z   <= ray.ax[2];
      start <= 1'b1;
      do @(posedge clock); while (busy);
      expected_hits.push_back(nearest_hit(ray));
      gap = with_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop start, let every pending result arrive, then let the pipe empty.
   task automatic wait_drained();
      start <= 1'b0;
      while (expected_hits.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Hold valid until the write is taken; the caller drops valid afterwards.
   task automatic write_csr(input csr_index_type idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_RADIUS_SQ) radius_sq_q = value;
      else length_q = value[30:0];
   endtask

   task automatic set_cylinder(input logic [31:0] rsq, input logic [31:0] len);
      wait_drained();
      write_csr(CSR_RADIUS_SQ, rsq);
      write_csr(CSR_LENGTH, len);
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Ray generators
   // ---------------------------------------------------------------
   function automatic logic signed [31:0] near_zero(input int units);
      return $signed($urandom_range(0, 2 * units * ONE)) - units * ONE;
   endfunction

   function automatic ray_type wild_ray();
      ray_type ray;
      for (int n = 0; n < 3; n++) begin
         ray.o[n] = $urandom;
         ray.d[n] = $urandom;
         ray.b[n] = $urandom;
         ray.ax[n] = $urandom;
      end
      return ray;
   endfunction

   // Plausible scene: unit-ish axis, small coordinates, often aimed at the body.
   function automatic ray_type scene_ray();
      ray_type ray;
      int sel, i;
      sel = $urandom_range(0, 9);
      for (int n = 0; n < 3; n++) ray.ax[n] = 0;
      i = $urandom_range(0, 2);
      if (sel < 6) begin
         ray.ax[i] = $urandom_range(0, 1) ? ONE : -ONE;
      end else if (sel < 9) begin
         ray.ax[i] = $urandom_range(0, 1) ? 46341 : -46341;
         ray.ax[(i + 1) % 3] = $urandom_range(0, 1) ? 46341 : -46341;
      end else begin
         for (int n = 0; n < 3; n++) ray.ax[n] = near_zero(2);  // not normalized
      end
      for (int n = 0; n < 3; n++) begin
         ray.b[n] = near_zero(4);
         ray.o[n] = ray.b[n] + near_zero(6);
         if ($urandom_range(0, 2) == 0)
            ray.d[n] = near_zero(2);
         else
            ray.d[n] = 32'((ray.b[n] + qmul(ray.ax[n], $urandom_range(0, 3 * ONE))
                            + near_zero(1) - ray.o[n]) >>> $urandom_range(0, 2));
      end
      return ray;
   endfunction

   function automatic ray_type uniform_ray(input logic signed [31:0] v);
      ray_type ray;
      for (int n = 0; n < 3; n++) begin
         ray.o[n] = v; ray.d[n] = v; ray.b[n] = v; ray.ax[n] = v;
      end
      return ray;
   endfunction

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------
   task automatic test_field_extremes();
      ray_type ray;
      send_ray(uniform_ray(32'sh7FFF_FFFF), 1'b1);
      send_ray(uniform_ray(32'sh8000_0000), 1'b1);
      send_ray(uniform_ray(32'sh0000_0000), 1'b1);
      send_ray(uniform_ray(32'shFFFF_FFFF), 1'b1);
      ray = uniform_ray(32'sh8000_0000);
      ray.o[0] = 32'sh7FFF_FFFF; ray.d[1] = 32'sh7FFF_FFFF; ray.ax[2] = 32'sh7FFF_FFFF;
      send_ray(ray, 1'b1);
   endtask

   task automatic test_special_cases();
      ray_type ray;
      ray = uniform_ray(0);
      ray.ax[2] = ONE;
      // direction along the axis: zero lateral term, miss
      ray.o[2] = -2 * ONE; ray.d[2] = ONE;
      send_ray(ray, 1'b1);
      // direction normal to the axis: caps skipped, side hit
      ray.o[2] = ONE / 2; ray.o[0] = -3 * ONE; ray.d[2] = 0; ray.d[0] = ONE;
      send_ray(ray, 1'b1);
      // slanted through the bottom cap
      ray.o[0] = 0; ray.o[2] = -2 * ONE; ray.d[0] = ONE / 8; ray.d[2] = ONE;
      send_ray(ray, 1'b1);
      // origin past the body: negative distances
      ray.o[0] = 3 * ONE; ray.o[2] = ONE / 2; ray.d[0] = ONE; ray.d[2] = ONE / 16;
      send_ray(ray, 1'b1);
      // tiny direction: the lateral term floors to zero, so a miss
      ray.o[0] = -100 * ONE; ray.d[0] = 1; ray.d[2] = 0;
      send_ray(ray, 1'b1);
      // axis of length two
      ray.ax[2] = 2 * ONE; ray.o[0] = -3 * ONE; ray.d[0] = ONE; ray.d[2] = ONE / 4;
      send_ray(ray, 1'b1);
      // side miss: passes beside the body
      ray.ax[2] = ONE; ray.o[1] = 5 * ONE; ray.d[2] = 0;
      send_ray(ray, 1'b1);
      // grazing tangent line at radius one
      ray.o[1] = ONE; ray.o[2] = ONE / 2;
      send_ray(ray, 1'b1);
   endtask

   task automatic test_random_rays(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 4) == 0) send_ray(wild_ray(), 1'b1);
         else send_ray(scene_ray(), $urandom_range(0, 3) != 0);
         // hold off until the pipe is empty at least once per phase
         if (i == count / 2) wait_drained();
      end
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------
   initial begin
      errors = 0;
      cycles = 0;
      radius_sq_q = RADIUS_SQ_RESET;
      length_q = LENGTH_RESET;
      reset = 1'b1;
      start = 1'b0;
      csr_valid = 1'b0;
      csr_index = CSR_RADIUS_SQ;
      csr_wdata = '0;
      {req_origin_x, req_origin_y, req_origin_z} = '0;
      {req_dir_x, req_dir_y, req_dir_z} = '0;
      {req_base_x, req_base_y, req_base_z} = '0;
      {req_axis_x, req_axis_y, req_axis_z} = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_field_extremes();
      test_special_cases();
      test_random_rays(120);

      set_cylinder(32'd4 << 16, 32'd3 << 16);
      test_special_cases();
      test_random_rays(120);

      set_cylinder(32'd0, 32'd0);
      test_field_extremes();
      test_random_rays(60);

      set_cylinder(32'hFFFF_FFFF, 32'h7FFF_FFFF);
      test_field_extremes();
      test_random_rays(60);

      set_cylinder(32'h0000_4000, 32'h0002_8000);
      test_random_rays(120);

      wait_drained();
      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
